// ===== rtl/lpps_pkg.sv =====
`timescale 1ns / 1ps
// Package for the line position PID steering block: constants, codes and the
// command and status structs shared by the controller and the datapath.
package lpps_pkg;

   localparam int NumSensors = 5;
   localparam int SensorIdxW = 3;
   localparam int SampleW = 10;
   localparam int CoefW = 32;
   localparam int ErrW = 14;
   localparam int DivW = 52;
   localparam int DivCntW = 6;
   localparam int DivisorW = 18;

   // The output divisor 256000 is 125 * 2^11: a shift by OutShift, then a
   // reciprocal multiplication by ceil(2^43 / 125), exact for inputs below 2^36.
   localparam int OutShift = 11;
   localparam int RecipInW = 36;
   localparam int RecipChunkW = 12;
   localparam int RecipSteps = 3;
   localparam int RecipShift = 43;
   localparam int RecipW = 73;
   localparam logic [RecipW-1:0] RecipMul = 73'd70368744178;

   localparam logic [9:0] WhiteLevel = 10'd1023;
   localparam logic [9:0] FullScale = 10'd1000;
   localparam logic [9:0] LostLimit = 10'd500;
   localparam logic [15:0] CenterQ8 = 16'd11520;

   localparam logic [2:0] CSR_KP = 3'd0;
   localparam logic [2:0] CSR_KI = 3'd1;
   localparam logic [2:0] CSR_KD = 3'd2;
   localparam logic [2:0] CSR_BLACK_ONE = 3'd3;
   localparam logic [2:0] CSR_BLACK_TWO = 3'd4;
   localparam logic [2:0] CSR_BLACK_THREE = 3'd5;
   localparam logic [2:0] CSR_BLACK_FOUR = 3'd6;
   localparam logic [2:0] CSR_BLACK_FIVE = 3'd7;

   localparam logic signed [31:0] KpReset = 32'sd6554;
   localparam logic signed [31:0] KiReset = 32'sd4587520;
   localparam logic signed [31:0] KdReset = 32'sd93622857;
   localparam logic [9:0] BlackReset [NumSensors] = '{10'd254, 10'd227, 10'd248, 10'd215,
                                                     10'd274};

   typedef enum logic [1:0] {
      DIV_SCALE,
      DIV_CENTROID,
      DIV_FINAL
   } div_kind_type;

   typedef enum logic [1:0] {
      MUL_P,
      MUL_I,
      MUL_D
   } mul_kind_type;

   typedef struct packed {
      logic capture;
      logic div_go;
      div_kind_type div_kind;
      logic [SensorIdxW-1:0] sensor;
      logic scale_acc;
      logic err_take;
      logic mul_go;
      mul_kind_type mul_kind;
      logic acc_init;
      logic acc_add;
      logic commit;
      logic hold;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
      logic line_found;
      logic rsp_free;
   } status_type;

   function automatic logic [6:0] sensor_weight(input logic [SensorIdxW-1:0] idx);
      logic [6:0] w;
      unique case (idx)
         3'd0: w = 7'd15;
         3'd1: w = 7'd30;
         3'd2: w = 7'd45;
         3'd3: w = 7'd60;
         3'd4: w = 7'd75;
         default: w = 7'd0;
      endcase
      return w;
   endfunction

endpackage

// ===== rtl/lpps_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer for the line position PID steering block.
// Depends on lpps_pkg; drives the datapath through cmd_type and reads status_type.
module lpps_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  lpps_pkg::status_type stat,
   output lpps_pkg::cmd_type cmd
);

   typedef enum logic [3:0] {
      IDLE, SCALE_GO, SCALE_WAIT, SCALE_ACC, CHECK, CENT_GO, CENT_WAIT, ERR,
      MUL0, MUL1, MUL2, ADD, FIN_GO, FIN_WAIT, COMMIT, HOLD
   } state_type;

   state_type state_ff, state_in;
   logic [lpps_pkg::SensorIdxW-1:0] idx_ff, idx_in;

   assign req_stall = (state_ff != IDLE);

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      cmd = '0;
      cmd.sensor = idx_ff;
      cmd.div_kind = lpps_pkg::DIV_SCALE;
      cmd.mul_kind = lpps_pkg::MUL_P;
      unique case (state_ff)
         IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               idx_in = '0;
               state_in = SCALE_GO;
            end
         end
         SCALE_GO: begin
            cmd.div_go = 1'b1;
            state_in = SCALE_WAIT;
         end
         SCALE_WAIT: begin
            if (!stat.div_busy) state_in = SCALE_ACC;
         end
         SCALE_ACC: begin
            cmd.scale_acc = 1'b1;
            if (idx_ff == lpps_pkg::SensorIdxW'(lpps_pkg::NumSensors - 1)) begin
               state_in = CHECK;
            end else begin
               idx_in = idx_ff + 1'b1;
               state_in = SCALE_GO;
            end
         end
         CHECK: begin
            state_in = stat.line_found ? CENT_GO : HOLD;
         end
         CENT_GO: begin
            cmd.div_go = 1'b1;
            cmd.div_kind = lpps_pkg::DIV_CENTROID;
            state_in = CENT_WAIT;
         end
         CENT_WAIT: begin
            if (!stat.div_busy) state_in = ERR;
         end
         ERR: begin
            cmd.err_take = 1'b1;
            state_in = MUL0;
         end
         MUL0: begin
            cmd.mul_go = 1'b1;
            cmd.mul_kind = lpps_pkg::MUL_P;
            cmd.acc_init = 1'b1;
            state_in = MUL1;
         end
         MUL1: begin
            cmd.mul_go = 1'b1;
            cmd.mul_kind = lpps_pkg::MUL_I;
            cmd.acc_add = 1'b1;
            state_in = MUL2;
         end
         MUL2: begin
            cmd.mul_go = 1'b1;
            cmd.mul_kind = lpps_pkg::MUL_D;
            cmd.acc_add = 1'b1;
            state_in = ADD;
         end
         ADD: begin
            cmd.acc_add = 1'b1;
            state_in = FIN_GO;
         end
         FIN_GO: begin
            cmd.div_go = 1'b1;
            cmd.div_kind = lpps_pkg::DIV_FINAL;
            state_in = FIN_WAIT;
         end
         FIN_WAIT: begin
            if (!stat.div_busy) state_in = COMMIT;
         end
         COMMIT: begin
            if (stat.rsp_free) begin
               cmd.commit = 1'b1;
               state_in = IDLE;
            end
         end
         HOLD: begin
            if (stat.rsp_free) begin
               cmd.hold = 1'b1;
               state_in = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         idx_ff <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
      end
   end

endmodule

// ===== rtl/lpps_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the line position PID steering block: configuration registers,
// sensor scaling, shared restoring divider, reciprocal output scaler, gain
// multiplier and output register. Depends on lpps_pkg; commanded by lpps_ctrl.
module lpps_dp (
   input  logic clock,
   input  logic reset,
   input  lpps_pkg::cmd_type cmd,
   output lpps_pkg::status_type stat,
   input  logic csr_write,
   input  logic [2:0] csr_index,
   input  logic [31:0] csr_data,
   input  logic [9:0] req_sample_one,
   input  logic [9:0] req_sample_two,
   input  logic [9:0] req_sample_three,
   input  logic [9:0] req_sample_four,
   input  logic [9:0] req_sample_five,
   input  logic rsp_stall,
   output logic rsp_valid,
   output logic signed [31:0] rsp_steering,
   output logic signed [13:0] rsp_position_error,
   output logic rsp_line_lost
);

   localparam int N = lpps_pkg::NumSensors;
   localparam int DW = lpps_pkg::DivW;
   localparam int VW = lpps_pkg::DivisorW;
   localparam int RW = lpps_pkg::RecipW;
   localparam int CW = lpps_pkg::RecipChunkW;
   localparam int IW = lpps_pkg::RecipInW;

   logic signed [31:0] kp_ff, ki_ff, kd_ff;
   logic [9:0] black_ff [N];
   logic [9:0] samp_ff [N];

   logic signed [13:0] err_ff, error_last_ff, error_older_ff;
   logic signed [31:0] steering_last_ff;

   logic [DW-1:0] dvd_ff, q_ff;
   logic [VW-1:0] rem_ff, divisor_ff;
   logic [lpps_pkg::DivCntW-1:0] cnt_ff;
   logic neg_ff;
   logic fin_ff;
   logic [RW-1:0] rcp_ff;

   logic [17:0] num_ff;
   logic [12:0] den_ff;
   logic any_hi_ff;

   logic signed [48:0] prod_ff;
   logic signed [DW-1:0] acc_ff;

   logic rsp_valid_ff, rsp_lost_ff;
   logic signed [31:0] rsp_steer_ff;
   logic signed [13:0] rsp_err_ff;

   logic [9:0] sel_samp, sel_black, clamped, diff, den_sel, scaled;
   logic [19:0] scale_num;
   logic [VW:0] rem_shift;
   logic rem_ge;
   logic [15:0] err_wide;
   logic signed [16:0] d1, d2, mul_b;
   logic signed [31:0] mul_a;
   logic [DW-1:0] acc_mag;
   logic [RW-1:0] rcp_step;
   logic [DW-1:0] quot;
   logic signed [31:0] steer_new;

   assign sel_samp = samp_ff[cmd.sensor];
   assign sel_black = black_ff[cmd.sensor];
   assign clamped = (sel_samp < sel_black) ? sel_black : sel_samp;
   assign diff = clamped - sel_black;
   assign den_sel = lpps_pkg::WhiteLevel - sel_black;
   assign scale_num = {10'd0, diff} * {10'd0, lpps_pkg::FullScale};
   assign scaled = (den_sel == 10'd0) ? 10'd0 : q_ff[9:0];

   assign rem_shift = {rem_ff, dvd_ff[DW-1]};
   assign rem_ge = (rem_shift >= {1'b0, divisor_ff});

   assign rcp_step = RW'(dvd_ff[IW-1 -: CW]) * lpps_pkg::RecipMul;
   assign quot = DW'(rcp_ff[RW-1:lpps_pkg::RecipShift]);

   assign err_wide = {1'b0, q_ff[14:0]} - lpps_pkg::CenterQ8;
   assign d1 = 17'(err_ff) - 17'(error_last_ff);
   assign d2 = 17'(err_ff) - (17'(error_last_ff) <<< 1) + 17'(error_older_ff);
   assign acc_mag = acc_ff[DW-1] ? DW'(-acc_ff) : DW'(acc_ff);

   always_comb begin
      unique case (cmd.mul_kind)
         lpps_pkg::MUL_P: begin
            mul_a = kp_ff;
            mul_b = d1;
         end
         lpps_pkg::MUL_I: begin
            mul_a = ki_ff;
            mul_b = 17'(err_ff);
         end
         lpps_pkg::MUL_D: begin
            mul_a = kd_ff;
            mul_b = d2;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      if (!neg_ff && quot > DW'(32'h7fff_ffff)) begin
         steer_new = 32'sh7fff_ffff;
      end else if (neg_ff && quot > DW'(32'h8000_0000)) begin
         steer_new = -32'sh7fff_ffff - 32'sd1;
      end else if (neg_ff) begin
         steer_new = -$signed(quot[31:0]);
      end else begin
         steer_new = $signed(quot[31:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff <= lpps_pkg::KpReset;
         ki_ff <= lpps_pkg::KiReset;
         kd_ff <= lpps_pkg::KdReset;
         for (int i = 0; i < N; i++) black_ff[i] <= lpps_pkg::BlackReset[i];
      end else if (csr_write) begin
         unique case (csr_index)
            lpps_pkg::CSR_KP: kp_ff <= csr_data;
            lpps_pkg::CSR_KI: ki_ff <= csr_data;
            lpps_pkg::CSR_KD: kd_ff <= csr_data;
            lpps_pkg::CSR_BLACK_ONE: black_ff[0] <= csr_data[9:0];
            lpps_pkg::CSR_BLACK_TWO: black_ff[1] <= csr_data[9:0];
            lpps_pkg::CSR_BLACK_THREE: black_ff[2] <= csr_data[9:0];
            lpps_pkg::CSR_BLACK_FOUR: black_ff[3] <= csr_data[9:0];
            lpps_pkg::CSR_BLACK_FIVE: black_ff[4] <= csr_data[9:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         samp_ff[0] <= req_sample_one;
         samp_ff[1] <= req_sample_two;
         samp_ff[2] <= req_sample_three;
         samp_ff[3] <= req_sample_four;
         samp_ff[4] <= req_sample_five;
         num_ff <= '0;
         den_ff <= '0;
         any_hi_ff <= 1'b0;
      end else if (cmd.scale_acc) begin
         num_ff <= num_ff + 18'({8'd0, scaled} * {11'd0, lpps_pkg::sensor_weight(cmd.sensor)});
         den_ff <= den_ff + 13'(scaled);
         any_hi_ff <= any_hi_ff | (scaled >= lpps_pkg::LostLimit);
      end
      if (cmd.err_take) err_ff <= $signed(err_wide[13:0]);
      if (cmd.mul_go) prod_ff <= 49'(mul_a) * 49'(mul_b);
      if (cmd.acc_init) begin
         acc_ff <= DW'({{12{steering_last_ff[31]}}, steering_last_ff, 8'd0});
      end else if (cmd.acc_add) begin
         acc_ff <= acc_ff + DW'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.div_go) begin
         rem_ff <= '0;
         q_ff <= '0;
         rcp_ff <= '0;
         fin_ff <= (cmd.div_kind == lpps_pkg::DIV_FINAL);
         unique case (cmd.div_kind)
            lpps_pkg::DIV_SCALE: begin
               dvd_ff <= {scale_num, 32'd0};
               divisor_ff <= VW'(den_sel);
               cnt_ff <= lpps_pkg::DivCntW'(20);
            end
            lpps_pkg::DIV_CENTROID: begin
               dvd_ff <= {num_ff, 8'd0, 26'd0};
               divisor_ff <= VW'(den_ff);
               cnt_ff <= lpps_pkg::DivCntW'(26);
            end
            lpps_pkg::DIV_FINAL: begin
               dvd_ff <= acc_mag >> lpps_pkg::OutShift;
               neg_ff <= acc_ff[DW-1];
               cnt_ff <= lpps_pkg::DivCntW'(lpps_pkg::RecipSteps);
            end
            default: cnt_ff <= '0;
         endcase
      end else if (cnt_ff != '0) begin
         if (fin_ff) begin
            rcp_ff <= {rcp_ff[RW-CW-1:0], {CW{1'b0}}} + rcp_step;
            dvd_ff <= {dvd_ff[DW-CW-1:0], {CW{1'b0}}};
         end else begin
            rem_ff <= rem_ge ? VW'(rem_shift - {1'b0, divisor_ff}) : rem_shift[VW-1:0];
            q_ff <= {q_ff[DW-2:0], rem_ge};
            dvd_ff <= {dvd_ff[DW-2:0], 1'b0};
         end
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         error_older_ff <= '0;
         error_last_ff <= '0;
         steering_last_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            error_older_ff <= error_last_ff;
            error_last_ff <= err_ff;
            steering_last_ff <= steer_new;
            rsp_steer_ff <= steer_new;
            rsp_err_ff <= err_ff;
            rsp_lost_ff <= 1'b0;
         end else if (cmd.hold) begin
            rsp_steer_ff <= steering_last_ff;
            rsp_err_ff <= error_last_ff;
            rsp_lost_ff <= 1'b1;
         end
         if (cmd.commit || cmd.hold) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign stat.div_busy = (cnt_ff != '0);
   assign stat.line_found = any_hi_ff;
   assign stat.rsp_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_steering = rsp_steer_ff;
   assign rsp_position_error = rsp_err_ff;
   assign rsp_line_lost = rsp_lost_ff;

endmodule

// ===== rtl/line_position_pid_steering.sv =====
`timescale 1ns / 1ps
// Line position PID steering: five line sensor samples in, one steering result out.
// Top level; instantiates lpps_ctrl and lpps_dp and uses lpps_pkg.
//
// The request channel (req_valid, req_stall) carries five raw 10-bit samples.
// The response channel (rsp_valid, rsp_stall) returns one transaction per request:
// steering in Q16.16, position error in signed Q6.8 and the line lost flag.
// The csr port writes gains (index 0 to 2) and black levels (index 3 to 7); the user
// must write only while the block is idle, which the block itself does not enforce.
// Writes to other indexes do nothing. One request is processed at a time. Each
// sensor is scaled by a 20-step division and the centroid takes a 26-step
// division, both in one shared restoring divider that retires one quotient bit
// per cycle; the output scaling is a shift and a 3-step reciprocal
// multiplication. The next request is accepted the cycle after the result is
// loaded into the output register.
// A stalled response holds in the output register; the next item then waits
// before its commit or hold step until that response is taken.
// Reset restores the default gains and black levels and clears the error
// history, steering state and response valid.
module line_position_pid_steering (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [9:0] req_sample_one,
   input  logic [9:0] req_sample_two,
   input  logic [9:0] req_sample_three,
   input  logic [9:0] req_sample_four,
   input  logic [9:0] req_sample_five,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic signed [31:0] rsp_steering,
   output logic signed [13:0] rsp_position_error,
   output logic rsp_line_lost,
   input  logic csr_write,
   input  logic [2:0] csr_index,
   input  logic [31:0] csr_data
);

   lpps_pkg::cmd_type cmd;
   lpps_pkg::status_type stat;

   lpps_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .stat(stat),
      .cmd(cmd)
   );

   lpps_dp u_dp (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .stat(stat),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .req_sample_one(req_sample_one),
      .req_sample_two(req_sample_two),
      .req_sample_three(req_sample_three),
      .req_sample_four(req_sample_four),
      .req_sample_five(req_sample_five),
      .rsp_stall(rsp_stall),
      .rsp_valid(rsp_valid),
      .rsp_steering(rsp_steering),
      .rsp_position_error(rsp_position_error),
      .rsp_line_lost(rsp_line_lost)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("Block did not go busy after accepting a transaction.");

   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("Response appeared without a transaction in progress.");

   a_no_commit_while_blocked: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit || cmd.hold) |-> stat.rsp_free)
      else $error("Result loaded while the output register was still occupied.");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for line_position_pid_steering: directed rows, register
// extremes, then random frames, each response checked against an in-bench steering
// predictor. Depends on lpps_pkg and the line_position_pid_steering RTL only.
module tb_top;

   typedef struct {
      logic [9:0] s [5];
      logic       known;
      logic signed [31:0] steer;
      logic signed [13:0] err;
      logic       lost;
   } frame_row_type;

   typedef struct {
      logic signed [31:0] steer;
      logic signed [13:0] err;
      logic       lost;
   } steer_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [9:0] req_sample [5];
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_steering;
   logic signed [13:0] rsp_position_error;
   logic rsp_line_lost;
   logic csr_write = 1'b0;
   logic [2:0] csr_index = lpps_pkg::CSR_KP;
   logic [31:0] csr_data = '0;

   longint gain_p, gain_i, gain_d;
   int unsigned black [5];
   longint err_prev2, err_prev1, steer_prev;

   steer_result_type expected_steering [$];
   frame_row_type directed_rows [$];
   int errors = 0;
   int checked = 0;
   int lost_seen = 0;
   longint cycles = 0;
   bit stall_mode = 0;

   initial for (int i = 0; i < 5; i++) req_sample[i] = '0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   line_position_pid_steering dut (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_sample_one(req_sample[0]), .req_sample_two(req_sample[1]),
      .req_sample_three(req_sample[2]), .req_sample_four(req_sample[3]),
      .req_sample_five(req_sample[4]), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_steering(rsp_steering), .rsp_position_error(rsp_position_error),
      .rsp_line_lost(rsp_line_lost), .csr_write(csr_write), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("MISMATCH %s: got %0d expected %0d (response %0d)", what, got, want, checked);
      errors++;
   endtask

   function automatic void reset_controller();
      gain_p = 6554;
      gain_i = 4587520;
      gain_d = 93622857;
      black = '{254, 227, 248, 215, 274};
      err_prev2 = 0;
      err_prev1 = 0;
      steer_prev = 0;
   endfunction

   function automatic void apply_register(input logic [2:0] idx, input logic [31:0] val);
      case (idx)
         lpps_pkg::CSR_KP: gain_p = longint'($signed(val));
         lpps_pkg::CSR_KI: gain_i = longint'($signed(val));
         lpps_pkg::CSR_KD: gain_d = longint'($signed(val));
         default: black[idx - lpps_pkg::CSR_BLACK_ONE] = val[9:0];
      endcase
   endfunction

   function automatic steer_result_type predict_steering(input logic [9:0] s [5]);
      steer_result_type r;
      longint num, den, e, total, u;
      int unsigned v, sc;
      logic found;
      num = 0;
      den = 0;
      found = 0;
      for (int i = 0; i < 5; i++) begin
         v = s[i];
         if (v < black[i]) v = black[i];
         sc = (black[i] == 1023) ? 0 : ((v - black[i]) * 1000) / (1023 - black[i]);
         if (sc >= 500) found = 1;
         num += longint'(sc) * (15 * (i + 1));
         den += sc;
      end
      if (found && den != 0) begin
         e = (num * 256) / den - 11520;
         total = steer_prev * 256 + gain_p * (e - err_prev1) + gain_i * e
               + gain_d * (e - 2 * err_prev1 + err_prev2);
         u = total / 256000;
         if (u > 64'sd2147483647) u = 64'sd2147483647;
         if (u < -64'sd2147483648) u = -64'sd2147483648;
         err_prev2 = err_prev1;
         err_prev1 = e;
         steer_prev = u;
      end else begin
         found = 0;
      end
      r.steer = steer_prev[31:0];
      r.err = err_prev1[13:0];
      r.lost = !found;
      return r;
   endfunction

   task automatic write_register(input logic [2:0] idx, input logic [31:0] val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      apply_register(idx, val);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_steering.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   // One frame; the gap before it is random, bursts come from a zero gap.
   task automatic send_frame(input logic [9:0] s [5], input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      for (int i = 0; i < 5; i++) req_sample[i] <= s[i];
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_steering.push_back(predict_steering(s));
   endtask

   function automatic void add_row(input int a, b, c, d, f, input logic known,
                                   input longint st, input longint er, input logic lo);
      frame_row_type r;
      r.s = '{10'(a), 10'(b), 10'(c), 10'(d), 10'(f)};
      r.known = known;
      r.steer = 32'(st);
      r.err = 14'(er);
      r.lost = lo;
      directed_rows.push_back(r);
   endfunction

   always @(posedge clock) begin
      cycles++;
      if (cycles > 64'd3000000) begin
         $display("Timeout after %0d cycles.", cycles);
         $display("** line_position_pid_steering: FAILED **");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ($urandom_range(0, 199) == 0) stall_mode <= !stall_mode;
         rsp_stall <= stall_mode ? ($urandom_range(0, 3) != 0) : 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_steering.size() == 0) begin
            report_mismatch("unexpected response", rsp_steering, 0);
         end else begin
            steer_result_type w;
            w = expected_steering.pop_front();
            if (rsp_steering !== w.steer) report_mismatch("steering", rsp_steering, w.steer);
            if (rsp_position_error !== w.err)
               report_mismatch("position_error", rsp_position_error, w.err);
            if (rsp_line_lost !== w.lost) report_mismatch("line_lost", rsp_line_lost, w.lost);
            if (w.lost) lost_seen++;
         end
         checked++;
      end
   end

   initial begin
      logic [9:0] s [5];
      int base;
      reset_controller();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      add_row(0, 0, 0, 0, 0, 1, 0, 0, 1);
      add_row(1023, 1023, 1023, 1023, 1023, 0, 0, 0, 0);
      add_row(1023, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(0, 0, 0, 0, 1023, 0, 0, 0, 0);
      add_row(0, 0, 1023, 0, 0, 0, 0, 0, 0);
      add_row(600, 600, 600, 600, 600, 0, 0, 0, 0);
      add_row(1023, 0, 0, 0, 1023, 0, 0, 0, 0);
      add_row(0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(0, 1023, 0, 1023, 0, 0, 0, 0, 0);
      add_row(1000, 800, 600, 400, 200, 0, 0, 0, 0);
      foreach (directed_rows[k]) begin
         frame_row_type r;
         r = directed_rows[k];
         if (r.known) begin
            steer_result_type p;
            p = predict_steering(r.s);
            if (p.steer !== r.steer || p.err !== r.err || p.lost !== r.lost)
               report_mismatch("directed row", k, 0);
         end
         send_frame(r.s, $urandom_range(0, 3));
      end
      wait_idle();

      // Gain and black-level extremes, including the zero-span dark level.
      write_register(lpps_pkg::CSR_KP, 32'h7FFF_FFFF);
      write_register(lpps_pkg::CSR_KI, 32'h8000_0000);
      write_register(lpps_pkg::CSR_KD, 32'h7FFF_FFFF);
      write_register(lpps_pkg::CSR_BLACK_ONE, 32'd1023);
      write_register(lpps_pkg::CSR_BLACK_TWO, 32'd0);
      write_register(lpps_pkg::CSR_BLACK_THREE, 32'd1022);
      write_register(lpps_pkg::CSR_BLACK_FOUR, 32'd0);
      write_register(lpps_pkg::CSR_BLACK_FIVE, 32'd512);
      for (int k = 0; k < 8; k++) begin
         s = '{1023, (k & 1) ? 10'd1023 : 10'd0, 1023, (k & 2) ? 10'd900 : 10'd0,
               (k & 4) ? 10'd1023 : 10'd0};
         send_frame(s, 0);
      end
      wait_idle();

      for (int phase = 0; phase < 6; phase++) begin
         if (phase == 5) begin
            write_register(lpps_pkg::CSR_KP, 32'h8000_0000);
            write_register(lpps_pkg::CSR_KI, 32'h7FFF_FFFF);
            write_register(lpps_pkg::CSR_KD, 32'h8000_0000);
         end else begin
            write_register(lpps_pkg::CSR_KP,
                           $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 200000));
            write_register(lpps_pkg::CSR_KI,
                           $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 9000000));
            write_register(lpps_pkg::CSR_KD,
                           $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1 << 27));
         end
         for (int i = 0; i < 5; i++)
            write_register(3'(lpps_pkg::CSR_BLACK_ONE + i), $urandom_range(0, 9) == 0 ?
                           $urandom_range(1000, 1023) : $urandom_range(0, 400));
         for (int n = 0; n < 180; n++) begin
            base = $urandom_range(0, 4);
            for (int i = 0; i < 5; i++) begin
               case ($urandom_range(0, 3))
                  0: s[i] = 10'($urandom);
                  1: s[i] = (i == base) ? 10'($urandom_range(850, 1023))
                                        : 10'($urandom_range(0, 600));
                  2: s[i] = 10'($urandom_range(0, 450));
                  default: s[i] = (i == base || i == base + 1) ? 10'd1023 : 10'd0;
               endcase
            end
            send_frame(s, ($urandom_range(0, 4) == 0) ? $urandom_range(1, 40) : 0);
         end
         wait_idle();
      end

      $display("Covered %0d responses (%0d with line lost) over 8 register settings.",
               checked, lost_seen);
      if (errors == 0 && expected_steering.size() == 0) begin
         $display("** line_position_pid_steering: PASSED **");
      end else begin
         $display("%0d mismatches, %0d responses still expected.", errors,
                  expected_steering.size());
         $display("** line_position_pid_steering: FAILED **");
      end
      $finish;
   end
endmodule
